@@ sv/evr_pkg.sv @@
`default_nettype none
package evr_pkg;

  // Quarter-wave sine coefficients, Q30
  localparam logic [31:0] TC1  = 32'd1686629713;
  localparam logic [31:0] TC3  = 32'd693598668;
  localparam logic [31:0] TC5  = 32'd85569306;
  localparam logic [31:0] TC7  = 32'd5026995;
  localparam logic [31:0] TC9  = 32'd172272;
  localparam logic [31:0] TC11 = 32'd3864;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Number of cells in the sine/cosine chain
  localparam int unsigned SIN_STEPS = 7;

  typedef logic [30:0] q30_t;

  // Coefficient fed in at Horner steps 1 to 5; step 0 squares u
  function automatic logic [31:0] step_coef(input int unsigned idx);
    logic [31:0] c;
    begin
      case (idx)
        1: c = TC9;
        2: c = TC7;
        3: c = TC5;
        4: c = TC3;
        5: c = TC1;
        default: c = '0;
      endcase
      return c;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/evr_trig_cell.sv @@
`default_nettype none
// One sine/cosine chain cell: one registered step (square u, Horner step
// or final multiply by u) for the sine and cosine argument of one angle.
module evr_trig_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic        clk,
  input  wire logic [30:0] u_s_in,
  input  wire logic [30:0] u2_s_in,
  input  wire logic [31:0] t_s_in,
  input  wire logic [30:0] u_c_in,
  input  wire logic [30:0] u2_c_in,
  input  wire logic [31:0] t_c_in,
  output      logic [30:0] u_s_out,
  output      logic [30:0] u2_s_out,
  output      logic [31:0] t_s_out,
  output      logic [30:0] u_c_out,
  output      logic [30:0] u2_c_out,
  output      logic [31:0] t_c_out
);
  import evr_pkg::*;

  logic [61:0] prod_s, prod_c;
  logic [31:0] t_s_next, t_c_next, u2_s_next, u2_c_next;

  always_comb begin
    prod_s = '0;
    prod_c = '0;
    t_s_next = t_s_in;
    t_c_next = t_c_in;
    u2_s_next = {1'b0, u2_s_in};
    u2_c_next = {1'b0, u2_c_in};
    if (IDX == 0) begin
      // square u, seed with TC11
      prod_s = u_s_in * u_s_in;
      prod_c = u_c_in * u_c_in;
      u2_s_next = 32'(prod_s >> 30);
      u2_c_next = 32'(prod_c >> 30);
      t_s_next = TC11;
      t_c_next = TC11;
    end else if (IDX < SIN_STEPS - 1) begin
      prod_s = 62'(t_s_in) * 62'(u2_s_in);
      prod_c = 62'(t_c_in) * 62'(u2_c_in);
      t_s_next = step_coef(IDX) - 32'(prod_s >> 30);
      t_c_next = step_coef(IDX) - 32'(prod_c >> 30);
    end else begin
      // final multiply by u, cap at one
      prod_s = 62'(t_s_in) * 62'(u_s_in);
      prod_c = 62'(t_c_in) * 62'(u_c_in);
      t_s_next = (prod_s >> 30) > 62'(Q30_ONE) ? 32'(Q30_ONE) : 32'(prod_s >> 30);
      t_c_next = (prod_c >> 30) > 62'(Q30_ONE) ? 32'(Q30_ONE) : 32'(prod_c >> 30);
    end
  end

  always_ff @(posedge clk) begin
    u_s_out  <= u_s_in;
    u_c_out  <= u_c_in;
    u2_s_out <= u2_s_next[30:0];
    u2_c_out <= u2_c_next[30:0];
    t_s_out  <= t_s_next;
    t_c_out  <= t_c_next;
  end
endmodule
`default_nettype wire

@@ sv/evr_rot_cell.sv @@
`default_nettype none
// Plane rotation cell: multiply stage, then round/combine/saturate stage.
module evr_rot_cell #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic signed [COORD_BITS-1:0] a_in,
  input  wire logic signed [COORD_BITS-1:0] b_in,
  input  wire logic signed [31:0]           s_in,
  input  wire logic signed [31:0]           c_in,
  output      logic signed [COORD_BITS-1:0] a_out,
  output      logic signed [COORD_BITS-1:0] b_out
);
  localparam int unsigned PW = COORD_BITS + 32;
  localparam logic signed [PW+1:0] HI = (PW+2)'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [PW+1:0] LO = -HI - 1;

  logic [PW-1:0] mag_ac, mag_bs, mag_as, mag_bc;
  logic          neg_ac, neg_bs, neg_as, neg_bc;

  function automatic logic [PW-1:0] mag_mul(input logic signed [COORD_BITS-1:0] x,
                                            input logic signed [31:0] s);
    logic [COORD_BITS-1:0] ux;
    logic [31:0]           us;
    begin
      ux = x[COORD_BITS-1] ? COORD_BITS'(-x) : x;
      us = s[31] ? 32'(-s) : s;
      return PW'(ux) * PW'(us);
    end
  endfunction

  function automatic logic signed [PW+1:0] rnd(input logic [PW-1:0] m, input logic n);
    logic [PW-1:0] r;
    begin
      r = (m + PW'(32'h2000_0000)) >> 30;
      return n ? -$signed({2'b00, r}) : $signed({2'b00, r});
    end
  endfunction

  logic signed [PW+1:0] na, nb;

  always_ff @(posedge clk) begin
    mag_ac <= mag_mul(a_in, c_in);
    mag_bs <= mag_mul(b_in, s_in);
    mag_as <= mag_mul(a_in, s_in);
    mag_bc <= mag_mul(b_in, c_in);
    neg_ac <= (a_in < 0) != (c_in < 0);
    neg_bs <= (b_in < 0) != (s_in < 0);
    neg_as <= (a_in < 0) != (s_in < 0);
    neg_bc <= (b_in < 0) != (c_in < 0);
  end

  always_comb begin
    na = rnd(mag_ac, neg_ac) - rnd(mag_bs, neg_bs);
    nb = rnd(mag_as, neg_as) + rnd(mag_bc, neg_bc);
  end

  always_ff @(posedge clk) begin
    a_out <= na > HI ? HI[COORD_BITS-1:0] : (na < LO ? LO[COORD_BITS-1:0] : na[COORD_BITS-1:0]);
    b_out <= nb > HI ? HI[COORD_BITS-1:0] : (nb < LO ? LO[COORD_BITS-1:0] : nb[COORD_BITS-1:0]);
  end
endmodule
`default_nettype wire

@@ sv/euler_vector_rotator.sv @@
`default_nettype none
// Euler vector rotator, Z then Y then X.
//
// Channels: raise start with vec_x/y/z and the three binary angles; the item
// is taken at that edge (busy is always low, so one item every cycle).
// Each result appears on rot_x/y/z for one cycle with done high.
//
// From the accepting edge to done, the item passes 15
// register stages, the first loaded at the accepting edge: phase decode (1),
// a 7-cell sine/cosine chain computing the three angles side by side (square
// u, five Horner steps, multiply by u), a quadrant sign stage (1), then 3
// rotation cells of 2 stages each, with the delayed coordinates riding
// alongside. Throughput is one item per cycle; every stage takes a new item
// each cycle.
//
// Reset clears the valid pipeline only; data registers are not reset.
// The receiver cannot stall: results must be taken the cycle they show.
module euler_vector_rotator #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [COORD_BITS-1:0] vec_x,
  input  wire logic signed [COORD_BITS-1:0] vec_y,
  input  wire logic signed [COORD_BITS-1:0] vec_z,
  input  wire logic        [ANGLE_BITS-1:0] angle_about_x,
  input  wire logic        [ANGLE_BITS-1:0] angle_about_y,
  input  wire logic        [ANGLE_BITS-1:0] angle_about_z,
  output      logic                         done,
  output      logic signed [COORD_BITS-1:0] rot_x,
  output      logic signed [COORD_BITS-1:0] rot_y,
  output      logic signed [COORD_BITS-1:0] rot_z
);
  import evr_pkg::*;

  localparam int unsigned TRIG_LAT = SIN_STEPS + 2; // decode + cells + sign
  localparam int unsigned LAT = TRIG_LAT + 6;

  assign busy = 1'b0;

  // valid shift line
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end
  assign done = vld[LAT-1];

  logic [ANGLE_BITS-1:0] ang [3];
  assign ang[0] = angle_about_z;
  assign ang[1] = angle_about_y;
  assign ang[2] = angle_about_x;

  logic signed [31:0] sin_v [3];
  logic signed [31:0] cos_v [3];

  for (genvar k = 0; k < 3; k++) begin : g_ang
    logic [31:0] p, pc;
    logic [30:0] us  [SIN_STEPS+1];
    logic [30:0] u2s [SIN_STEPS+1];
    logic [31:0] ts  [SIN_STEPS+1];
    logic [30:0] uc  [SIN_STEPS+1];
    logic [30:0] u2c [SIN_STEPS+1];
    logic [31:0] tc  [SIN_STEPS+1];
    logic [1:0]  qs  [SIN_STEPS+1];
    logic [1:0]  qc  [SIN_STEPS+1];

    assign p  = 32'({ang[k], 32'd0} >> ANGLE_BITS);
    assign pc = p + 32'h4000_0000;

    // decode quadrant, fold the phase
    always_ff @(posedge clk) begin
      us[0]  <= p[30]  ? 31'(Q30_ONE - {1'b0, p[29:0]})  : {1'b0, p[29:0]};
      uc[0]  <= pc[30] ? 31'(Q30_ONE - {1'b0, pc[29:0]}) : {1'b0, pc[29:0]};
      qs[0]  <= p[31:30];
      qc[0]  <= pc[31:30];
    end
    assign u2s[0] = '0;
    assign u2c[0] = '0;
    assign ts[0]  = '0;
    assign tc[0]  = '0;

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_cell
      evr_trig_cell #(.IDX(i)) u_cell (
        .clk, .u_s_in(us[i]), .u2_s_in(u2s[i]), .t_s_in(ts[i]),
        .u_c_in(uc[i]), .u2_c_in(u2c[i]), .t_c_in(tc[i]),
        .u_s_out(us[i+1]), .u2_s_out(u2s[i+1]), .t_s_out(ts[i+1]),
        .u_c_out(uc[i+1]), .u2_c_out(u2c[i+1]), .t_c_out(tc[i+1])
      );
      always_ff @(posedge clk) begin
        qs[i+1] <= qs[i];
        qc[i+1] <= qc[i];
      end
    end

    // apply quadrant sign
    always_ff @(posedge clk) begin
      sin_v[k] <= qs[SIN_STEPS][1] ? -$signed(ts[SIN_STEPS]) : $signed(ts[SIN_STEPS]);
      cos_v[k] <= qc[SIN_STEPS][1] ? -$signed(tc[SIN_STEPS]) : $signed(tc[SIN_STEPS]);
    end
  end

  // delay coordinates to meet the trig values; later angles wait longer
  logic signed [COORD_BITS-1:0] dx [TRIG_LAT], dy [TRIG_LAT], dz [TRIG_LAT+2];
  logic signed [31:0] sy [2], cy [2], sx [4], cx [4];
  always_ff @(posedge clk) begin
    dx[0] <= vec_x;
    dy[0] <= vec_y;
    dz[0] <= vec_z;
    for (int i = 1; i < TRIG_LAT; i++) begin
      dx[i] <= dx[i-1];
      dy[i] <= dy[i-1];
    end
    for (int i = 1; i < TRIG_LAT + 2; i++) dz[i] <= dz[i-1];
    sy[0] <= sin_v[1]; cy[0] <= cos_v[1];
    sy[1] <= sy[0];    cy[1] <= cy[0];
    sx[0] <= sin_v[2]; cx[0] <= cos_v[2];
    for (int i = 1; i < 4; i++) begin
      sx[i] <= sx[i-1];
      cx[i] <= cx[i-1];
    end
  end

  logic signed [COORD_BITS-1:0] x1, y1, z2, x2, y3, z3, y2d [2], x2d [2];

  // about Z
  evr_rot_cell #(.COORD_BITS(COORD_BITS)) u_rz (
    .clk, .a_in(dx[TRIG_LAT-1]), .b_in(dy[TRIG_LAT-1]),
    .s_in(sin_v[0]), .c_in(cos_v[0]), .a_out(x1), .b_out(y1));

  // about Y: (z, x)
  evr_rot_cell #(.COORD_BITS(COORD_BITS)) u_ry (
    .clk, .a_in(dz[TRIG_LAT+1]), .b_in(x1),
    .s_in(sy[1]), .c_in(cy[1]), .a_out(z2), .b_out(x2));

  always_ff @(posedge clk) begin
    y2d[0] <= y1;
    y2d[1] <= y2d[0];
    x2d[0] <= x2;
    x2d[1] <= x2d[0];
  end

  // about X: (y, z)
  evr_rot_cell #(.COORD_BITS(COORD_BITS)) u_rx (
    .clk, .a_in(y2d[1]), .b_in(z2),
    .s_in(sx[3]), .c_in(cx[3]), .a_out(y3), .b_out(z3));

  assign rot_x = x2d[1];
  assign rot_y = y3;
  assign rot_z = z3;
endmodule
`default_nettype wire
